>>> design/led_blink_and_breathing_pattern_defines.svh
// Assertion macros shared by the LED blink and breathing pattern design.
`ifndef LED_BLINK_AND_BREATHING_PATTERN_DEFINES_SVH
`define LED_BLINK_AND_BREATHING_PATTERN_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define LBBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LBBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define LBBP_ASSERT_IMP(lbl, ante, cons)
`define LBBP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/lbbp_pkg.sv
// Package with the types and constants of the LED blink and breathing pattern design.
package lbbp_pkg;

    localparam int DUTY_W      = 16;
    localparam int COUNT_W     = 8;
    localparam int PCNT_W      = COUNT_W + 1;
    localparam int WAIT_W      = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int RAMP_W      = DUTY_W + 2;

    localparam int DEF_RAMP_STEP   = 10;
    localparam int DEF_RAMP_PERIOD = 5;

    localparam logic [DUTY_W-1:0] DUTY_FULL = '1;
    localparam logic [DUTY_W-1:0] DUTY_OFF  = '0;

    localparam logic [WAIT_W-1:0] PULSE_ON_RST   = 16'd200;
    localparam logic [WAIT_W-1:0] PULSE_OFF_RST  = 16'd200;
    localparam logic [DUTY_W-1:0] BREATH_MIN_RST = 16'd0;
    localparam logic [DUTY_W-1:0] BREATH_MAX_RST = 16'hFFFF;

    // Register indexes of the configuration channel.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PULSE_ON   = 8'd0,
        CFG_PULSE_OFF  = 8'd1,
        CFG_BREATH_MIN = 8'd2,
        CFG_BREATH_MAX = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [WAIT_W-1:0] pulse_on_ticks;
        logic [WAIT_W-1:0] pulse_off_ticks;
        logic [DUTY_W-1:0] breath_min_duty;
        logic [DUTY_W-1:0] breath_max_duty;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_now;
        logic              ramp_down;
        logic              lit_phase;
        logic [WAIT_W-1:0] wait_left;
        logic [PCNT_W-1:0] pulse_counter;
    } status_t;

endpackage

>>> design/lbbp_ifs.sv
// Handshake interfaces for the item, result and configuration channels.
interface lbbp_item_if;
    import lbbp_pkg::*;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COUNT_W-1:0] burst_pulses;
    logic               error_on;

    modport source (output valid, mode, burst_pulses, error_on, input ready);
    modport sink (input valid, mode, burst_pulses, error_on, output ready);
endinterface

interface lbbp_result_if;
    import lbbp_pkg::*;
    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  fault_duty;
    logic [DUTY_W-1:0]  status_duty;
    logic [COUNT_W-1:0] pulses_left;

    modport source (output valid, fault_duty, status_duty, pulses_left, input ready);
    modport sink (input valid, fault_duty, status_duty, pulses_left, output ready);
endinterface

interface lbbp_cfg_if;
    import lbbp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [DUTY_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/lbbp_status.sv
// Next-state logic of the status LED: burst phases and the heartbeat ramp.
module lbbp_status
    import lbbp_pkg::*;
#(
    parameter int RAMP_STEP   = DEF_RAMP_STEP,
    parameter int RAMP_PERIOD = DEF_RAMP_PERIOD
)
(
    input  cfg_t               cfg,
    input  status_t            cur,
    input  logic               start,
    input  logic [COUNT_W-1:0] burst_pulses,
    output status_t            nxt
);

    localparam logic signed [RAMP_W-1:0] STEP_S   = RAMP_W'(RAMP_STEP);
    localparam logic [WAIT_W-1:0]        PERIOD_T = WAIT_W'(RAMP_PERIOD);

    status_t                   work;
    logic                      upd;
    logic signed [RAMP_W-1:0]  duty_s;
    logic signed [RAMP_W-1:0]  ramp_sum;
    logic signed [RAMP_W-1:0]  lo_s;
    logic signed [RAMP_W-1:0]  hi_s;

    // Ramp arithmetic in a signed width that holds one step past either end.
    assign duty_s   = $signed({2'b00, cur.duty_now});
    assign lo_s     = $signed({2'b00, cfg.breath_min_duty});
    assign hi_s     = $signed({2'b00, cfg.breath_max_duty});
    assign ramp_sum = cur.ramp_down ? (duty_s - STEP_S) : (duty_s + STEP_S);

    always_comb
    begin
        work = cur;
        // A start event arms the burst and updates at once; a tick counts the wait down.
        if (start)
        begin
            work.pulse_counter = {1'b0, burst_pulses} + PCNT_W'(1);
            work.lit_phase     = 1'b0;
            upd                = 1'b1;
        end
        else
        begin
            if (cur.wait_left != '0)
            begin
                work.wait_left = cur.wait_left - WAIT_W'(1);
            end
            upd = (work.wait_left == '0);
        end

        nxt = work;
        if (upd)
        begin
            if (work.pulse_counter != '0)
            begin
                // Burst phase: an on phase lights fully, an off phase uses up a pulse.
                if (work.lit_phase)
                begin
                    nxt.duty_now  = DUTY_FULL;
                    nxt.wait_left = cfg.pulse_on_ticks;
                end
                else
                begin
                    nxt.duty_now      = DUTY_OFF;
                    nxt.wait_left     = cfg.pulse_off_ticks;
                    nxt.pulse_counter = work.pulse_counter - PCNT_W'(1);
                end
                nxt.lit_phase = !work.lit_phase;
            end
            else
            begin
                // Heartbeat: one step, clamped and reflected at the bounds.
                nxt.wait_left = PERIOD_T;
                priority if (ramp_sum < lo_s)
                begin
                    nxt.duty_now  = cfg.breath_min_duty;
                    nxt.ramp_down = 1'b0;
                end
                else if (ramp_sum > hi_s)
                begin
                    nxt.duty_now  = cfg.breath_max_duty;
                    nxt.ramp_down = 1'b1;
                end
                else
                begin
                    nxt.duty_now = ramp_sum[DUTY_W-1:0];
                end
            end
        end
    end

endmodule

>>> design/led_blink_and_breathing_pattern.sv
// Top level of the LED blink and breathing pattern generator.
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless the result stalls; the state update is
// a single pass of compare, add and clamp between state and result registers.
// Reset: state clears, configuration registers return to 200, 200, 0 and 65535,
// and the block accepts items from the first cycle after reset.
`include "led_blink_and_breathing_pattern_defines.svh"

module led_blink_and_breathing_pattern
    import lbbp_pkg::*;
#(
    parameter int RAMP_STEP   = DEF_RAMP_STEP,
    parameter int RAMP_PERIOD = DEF_RAMP_PERIOD
)
(
    input  logic          clk,
    input  logic          rst_n,
    lbbp_item_if.sink     item,
    lbbp_result_if.source result,
    lbbp_cfg_if.sink      cfg
);

    cfg_t               cfg_reg;
    status_t            state_reg;
    status_t            state_next;
    logic               res_valid_reg;
    logic [DUTY_W-1:0]  err_duty_reg;
    logic [DUTY_W-1:0]  stat_duty_reg;
    logic [COUNT_W-1:0] pulses_left_reg;
    logic               item_xfer;
    logic               res_xfer;

    // Configuration writes are always taken; unknown indexes are ignored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_on_ticks  <= PULSE_ON_RST;
            cfg_reg.pulse_off_ticks <= PULSE_OFF_RST;
            cfg_reg.breath_min_duty <= BREATH_MIN_RST;
            cfg_reg.breath_max_duty <= BREATH_MAX_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PULSE_ON:   cfg_reg.pulse_on_ticks  <= cfg.data;
                CFG_PULSE_OFF:  cfg_reg.pulse_off_ticks <= cfg.data;
                CFG_BREATH_MIN: cfg_reg.breath_min_duty <= cfg.data;
                CFG_BREATH_MAX: cfg_reg.breath_max_duty <= cfg.data;
                default:        ;
            endcase
        end
    end

    // The result register frees up in the same cycle its transfer completes.
    assign item.ready = !res_valid_reg || result.ready;
    assign item_xfer  = item.valid && item.ready;
    assign res_xfer   = res_valid_reg && result.ready;

    lbbp_status #(
        .RAMP_STEP   (RAMP_STEP),
        .RAMP_PERIOD (RAMP_PERIOD)
    ) u_status (
        .cfg          (cfg_reg),
        .cur          (state_reg),
        .start        (item.mode),
        .burst_pulses (item.burst_pulses),
        .nxt          (state_next)
    );

    // Status state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (item_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (item_xfer)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_xfer)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload, with the pulse count saturated to its output width.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            err_duty_reg    <= item.error_on ? DUTY_FULL : DUTY_OFF;
            stat_duty_reg   <= state_next.duty_now;
            pulses_left_reg <= state_next.pulse_counter[PCNT_W-1] ? '1
                                : state_next.pulse_counter[COUNT_W-1:0];
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.fault_duty  = err_duty_reg;
    assign result.status_duty = stat_duty_reg;
    assign result.pulses_left = pulses_left_reg;

    // Checks on the pipeline and the burst state.
    `LBBP_ASSERT_NEXT(a_item_gives_result, item_xfer, res_valid_reg)
    `LBBP_ASSERT_IMP(a_burst_duty_matches_phase, state_reg.pulse_counter != '0,
        state_reg.duty_now == (state_reg.lit_phase ? DUTY_OFF : DUTY_FULL))
    `LBBP_ASSERT_NEXT(a_start_sets_pulses, item_xfer && item.mode,
        pulses_left_reg == $past(item.burst_pulses))
    `LBBP_ASSERT_NEXT(a_wait_holds_duty,
        item_xfer && !item.mode && state_reg.wait_left > WAIT_W'(1),
        state_reg.duty_now == $past(state_reg.duty_now))

endmodule

>>> test/led_blink_and_breathing_pattern_tb.sv
// Self-checking testbench for the LED blink and breathing pattern generator.
module led_blink_and_breathing_pattern_tb
    import lbbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_BURST = 1'b1;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_ITEMS     = 220;

    typedef struct packed {
        logic               mode;
        logic [COUNT_W-1:0] burst;
        logic               err;
    } led_cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  err_duty;
        logic [DUTY_W-1:0]  stat_duty;
        logic [COUNT_W-1:0] left;
    } led_out_t;

    logic clk;
    logic rst_n;

    lbbp_item_if   item_ch();
    lbbp_result_if res_ch();
    lbbp_cfg_if    cfg_ch();

    led_blink_and_breathing_pattern u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Mirror of the block's pattern state and registers.
    logic [DUTY_W-1:0] led_duty;
    logic              falling;
    logic              pulse_lit;
    logic [WAIT_W-1:0] hold_ticks;
    logic [PCNT_W-1:0] pulses_owed;
    logic [WAIT_W-1:0] on_ticks;
    logic [WAIT_W-1:0] off_ticks;
    logic [DUTY_W-1:0] floor_duty;
    logic [DUTY_W-1:0] ceil_duty;

    led_out_t pending_q[$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int fail_count   = 0;
    int items_sent   = 0;
    int bursts_sent  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Moves the status LED on by one burst phase or one ramp step.
    function automatic void advance_status();
        int d;
        if (pulses_owed != 0)
        begin
            if (pulse_lit)
            begin
                led_duty   = DUTY_FULL;
                hold_ticks = on_ticks;
            end
            else
            begin
                led_duty    = DUTY_OFF;
                hold_ticks  = off_ticks;
                pulses_owed = pulses_owed - 1'b1;
            end
            pulse_lit = ~pulse_lit;
        end
        else
        begin
            d = int'(led_duty);
            d = falling ? d - DEF_RAMP_STEP : d + DEF_RAMP_STEP;
            // The lower bound is tested first, which matters when the bounds cross.
            if (d < int'(floor_duty))
            begin
                d       = int'(floor_duty);
                falling = 1'b0;
            end
            else if (d > int'(ceil_duty))
            begin
                d       = int'(ceil_duty);
                falling = 1'b1;
            end
            led_duty   = d[DUTY_W-1:0];
            hold_ticks = WAIT_W'(DEF_RAMP_PERIOD);
        end
    endfunction

    // Works out the LED duties that follow one accepted command.
    function automatic led_out_t predict_led(led_cmd_t cmd);
        led_out_t o;
        if (cmd.mode == MODE_BURST)
        begin
            pulses_owed = {1'b0, cmd.burst} + 1'b1;
            pulse_lit   = 1'b0;
            advance_status();
        end
        else
        begin
            if (hold_ticks != 0)
                hold_ticks = hold_ticks - 1'b1;
            if (hold_ticks == 0)
                advance_status();
        end
        o.err_duty  = cmd.err ? DUTY_FULL : DUTY_OFF;
        o.stat_duty = led_duty;
        o.left      = (pulses_owed > 9'd255) ? 8'd255 : pulses_owed[COUNT_W-1:0];
        return o;
    endfunction

    task automatic report_fault(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Offers one command, with random idle cycles beforehand, until it is taken.
    task automatic send_cmd(input logic mode, input logic [COUNT_W-1:0] burst,
                            input logic err);
        led_cmd_t cmd;
        cmd.mode  = mode;
        cmd.burst = burst;
        cmd.err   = err;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= mode;
        item_ch.burst_pulses <= burst;
        item_ch.error_on     <= err;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        pending_q.push_back(predict_led(cmd));
        items_sent++;
        if (mode == MODE_BURST)
            bursts_sent++;
    endtask

    // Stops offering commands and waits for every outstanding result.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [DUTY_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_PULSE_ON:   on_ticks   = value;
            CFG_PULSE_OFF:  off_ticks  = value;
            CFG_BREATH_MIN: floor_duty = value;
            CFG_BREATH_MAX: ceil_duty  = value;
            default: ;
        endcase
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [WAIT_W-1:0] on_t, input logic [WAIT_W-1:0] off_t,
                               input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] hi);
        drain();
        write_reg(CFG_PULSE_ON, on_t);
        write_reg(CFG_PULSE_OFF, off_t);
        write_reg(CFG_BREATH_MIN, lo);
        write_reg(CFG_BREATH_MAX, hi);
    endtask

    // Phase lengths: mostly short, now and then zero, all ones or wide.
    function automatic logic [WAIT_W-1:0] pick_ticks();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return WAIT_W'($urandom_range(65535));
            3:       return WAIT_W'($urandom_range(20, 300));
            default: return WAIT_W'($urandom_range(0, 6));
        endcase
    endfunction

    // Ramp bounds chosen so that clamping happens often, including crossed bounds.
    task automatic random_config();
        logic [DUTY_W-1:0] lo;
        logic [DUTY_W-1:0] hi;
        case ($urandom_range(4))
            0:
            begin
                lo = DUTY_W'($urandom_range(0, 60));
                hi = lo + DUTY_W'($urandom_range(0, 200));
            end
            1:
            begin
                lo = DUTY_W'($urandom_range(65400, 65535));
                hi = DUTY_FULL;
            end
            2:
            begin
                lo = DUTY_W'($urandom_range(100, 400));
                hi = DUTY_W'($urandom_range(0, 99));
            end
            3:
            begin
                lo = DUTY_W'($urandom_range(65535));
                hi = DUTY_W'($urandom_range(65535));
            end
            default:
            begin
                lo = DUTY_OFF;
                hi = DUTY_W'($urandom_range(0, 100));
            end
        endcase
        load_config(pick_ticks(), pick_ticks(), lo, hi);
    endtask

    // Mostly ticks, with the odd burst start of mostly few pulses.
    task automatic run_random(input int n);
        int                 r;
        logic [COUNT_W-1:0] count;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                count = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(255))
                                                 : COUNT_W'($urandom_range(0, 3));
            else
                count = COUNT_W'($urandom);
            send_cmd((r < 10) ? MODE_BURST : MODE_TICK, count, 1'($urandom_range(1)));
        end
    endtask

    task automatic random_phase(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (2)
        begin
            random_config();
            run_random(PHASE_ITEMS);
        end
    endtask

    // Hand-picked sequences: error flag, burst limits, zero periods, bound corners.
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_cmd(MODE_TICK, 8'h00, 1'b1);
        send_cmd(MODE_TICK, 8'hFF, 1'b0);
        send_cmd(MODE_BURST, 8'd255, 1'b1);
        // Short on phase and a zero-length off phase.
        load_config(16'd2, 16'd0, 16'd20, 16'd45);
        send_cmd(MODE_BURST, 8'd2, 1'b0);
        repeat (5) send_cmd(MODE_TICK, 8'h00, 1'b1);
        // A burst of zero gives a single off phase before the ramp resumes.
        send_cmd(MODE_BURST, 8'd0, 1'b0);
        repeat (2) send_cmd(MODE_TICK, 8'h00, 1'b0);
        // Ramp pinned against the top of the duty range.
        load_config(16'd0, 16'd0, 16'd65530, 16'hFFFF);
        repeat (5) send_cmd(MODE_TICK, 8'h55, 1'b1);
        // Lower bound above the upper bound, and the longest on phase.
        load_config(16'hFFFF, 16'd1, 16'd300, 16'd100);
        repeat (5) send_cmd(MODE_TICK, 8'hAA, 1'b0);
        send_cmd(MODE_BURST, 8'd1, 1'b1);
        send_cmd(MODE_TICK, 8'h00, 1'b1);
    endtask

    task automatic test_no_idling();
        random_phase(0, 0);
    endtask

    task automatic test_sender_idle();
        random_phase(79, 0);
    endtask

    task automatic test_receiver_stall();
        random_phase(0, 79);
    endtask

    task automatic test_mixed_idle();
        random_phase(9, 9);
    endtask

    // Long receiver hold-off so the block fills and back-pressures its input.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        random_config();
        hold_left = HOLD_OFF_CYCLES;
        run_random(60);
        drain();
        run_random(20);
    endtask

    // Result ready: a counted hold-off when requested, otherwise random stalls.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compares every result transfer with the oldest outstanding prediction.
    always @(posedge clk)
    begin : check_results
        led_out_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_q.size() == 0)
                report_fault("result transfer with no command outstanding");
            else
            begin
                want = pending_q.pop_front();
                if (res_ch.fault_duty !== want.err_duty)
                    report_fault($sformatf("fault_duty: got %0d, expected %0d",
                                           res_ch.fault_duty, want.err_duty));
                if (res_ch.status_duty !== want.stat_duty)
                    report_fault($sformatf("status_duty: got %0d, expected %0d",
                                           res_ch.status_duty, want.stat_duty));
                if (res_ch.pulses_left !== want.left)
                    report_fault($sformatf("pulses_left: got %0d, expected %0d",
                                           res_ch.pulses_left, want.left));
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("led_blink_and_breathing_pattern_tb: timed out after %0d quiet cycles",
                 STALL_LIMIT);
        $display("led_blink_and_breathing_pattern_tb: errors");
        $finish;
    end

    // Main sequence.
    initial
    begin : stimulus
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.mode         <= MODE_TICK;
        item_ch.burst_pulses <= '0;
        item_ch.error_on     <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_PULSE_ON;
        cfg_ch.data          <= '0;

        led_duty    = DUTY_OFF;
        falling     = 1'b0;
        pulse_lit   = 1'b0;
        hold_ticks  = '0;
        pulses_owed = '0;
        on_ticks    = PULSE_ON_RST;
        off_ticks   = PULSE_OFF_RST;
        floor_duty  = BREATH_MIN_RST;
        ceil_duty   = BREATH_MAX_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_mixed_idle();
        test_backpressure();
        drain();

        $display("Run covered %0d commands (%0d burst starts), %0d results, %0d register writes,",
                 items_sent, bursts_sent, results_seen, cfg_writes);
        $display("with back-to-back, sender gaps, receiver stalls, mixed gaps and a long hold-off.");
        if (fail_count == 0)
            $display("led_blink_and_breathing_pattern_tb: clean");
        else
            $display("led_blink_and_breathing_pattern_tb: errors");
        $finish;
    end

endmodule
